// File: rtl/wcc_pkg.sv
// Shared types and constants of the wildcard contingency counter.
// Depends on nothing; every module of the block but wcc_ram imports it.
`default_nettype none

package wcc_pkg;

  // parameter defaults
  localparam int DEF_MAX_COLUMNS = 4;
  localparam int DEF_MAX_LEVELS  = 16;
  localparam int DEF_COUNT_WIDTH = 16;
  localparam int DEF_TABLE_DEPTH = 65536;

  // fixed field widths
  localparam int NUM_COLS  = 4;
  localparam int VAL_W     = 4;
  localparam int LEV_W     = 5;
  localparam int NCOL_W    = 3;
  localparam int OUT_W     = 16;
  localparam int OP_W      = 2;
  localparam int REG_IDX_W = 3;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_INC   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEC   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_NUM_COLUMNS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEVELS_COL0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEVELS_COL1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LEVELS_COL2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LEVELS_COL3 = 3'd4;

  localparam logic [NCOL_W-1:0] RST_NUM_COLUMNS = 3'd4;
  localparam logic [LEV_W-1:0]  RST_LEVELS      = 5'd16;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LEV,
    ST_MUL_DIG,
    ST_ACC,
    ST_REDUCE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } wcc_state_t;

  typedef struct packed {
    logic       load;
    wcc_state_t state;
  } agen_ctrl_t;

  typedef struct packed {
    logic col_last;
    logic red_last;
    logic walk_last;
  } agen_stat_t;

  typedef struct packed {
    logic load;
    logic issue;
  } cu_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/wcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module wcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/wcc_addr_gen.sv
// Address generator: mixed-radix setup on one shared multiplier, modulo
// reduction of base and step values, then the wildcard odometer walk.
// Depends on wcc_pkg.
`default_nettype none

module wcc_addr_gen #(
  parameter int MAX_COLUMNS = wcc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_LEVELS  = wcc_pkg::DEF_MAX_LEVELS,
  parameter int TABLE_DEPTH = wcc_pkg::DEF_TABLE_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  wcc_pkg::agen_ctrl_t                              ctrl,
  input  logic [wcc_pkg::NCOL_W-1:0]                       num_columns,
  input  logic [wcc_pkg::NUM_COLS-1:0][wcc_pkg::LEV_W-1:0] levels,
  input  logic [wcc_pkg::NUM_COLS-1:0][wcc_pkg::VAL_W-1:0] values,
  input  logic [wcc_pkg::NUM_COLS-1:0]                     missing_mask,
  output logic [AW-1:0]                                    addr,
  output wcc_pkg::agen_stat_t                              stat
);
  import wcc_pkg::*;

  localparam int NC      = (MAX_COLUMNS < NUM_COLS) ? MAX_COLUMNS : NUM_COLS;
  localparam int LEV_TOP = (1 << LEV_W) - 1;
  localparam int LEV_CAP = (MAX_LEVELS < LEV_TOP) ? MAX_LEVELS : LEV_TOP;
  localparam int FA_W    = $clog2(LEV_CAP ** NC + 1);
  localparam int XW      = ((FA_W > AW) ? FA_W : AW) + 1;
  localparam int DL      = $clog2(TABLE_DEPTH);
  localparam int RED_K   = (FA_W > DL) ? FA_W - DL : 0;
  localparam int RK_W    = $clog2(RED_K + 2);
  localparam int MW      = FA_W + LEV_W;

  logic [NCOL_W-1:0]                 n_used;
  logic [NUM_COLS-1:0][LEV_W-1:0]    lev;
  logic [NUM_COLS-1:0][LEV_W-1:0]    dig_init;

  logic [NUM_COLS-1:0][LEV_W-1:0]    dig;
  logic [NUM_COLS-1:0]               wild;
  logic [1:0]                        col;
  logic [RK_W-1:0]                   rk;
  logic [FA_W-1:0]                   stride;
  logic [FA_W-1:0]                   wrap;
  logic [FA_W-1:0]                   prod;
  logic [XW-1:0]                     base;
  logic [NUM_COLS-1:0][XW-1:0]       delta;

  logic [LEV_W-1:0]                  mul_b;
  logic [MW-1:0]                     mul_p;
  logic [XW-1:0]                     dshift;
  logic [NUM_COLS-1:0]               inc_here;
  logic [NUM_COLS-1:0]               wrap_here;
  logic                              found;
  logic [XW-1:0]                     delta_sel;
  logic [XW-1:0]                     addr_sum;
  logic [XW-1:0]                     addr_next;

  // clamp column count and level counts
  always_comb begin
    if (num_columns == '0) begin
      n_used = NCOL_W'(1);
    end else if (num_columns > NCOL_W'(NC)) begin
      n_used = NCOL_W'(NC);
    end else begin
      n_used = num_columns;
    end
    for (int c = 0; c < NUM_COLS; c++) begin
      if (levels[c] == '0) begin
        lev[c] = LEV_W'(1);
      end else if (levels[c] > LEV_W'(LEV_CAP)) begin
        lev[c] = LEV_W'(LEV_CAP);
      end else begin
        lev[c] = levels[c];
      end
      if (missing_mask[c]) begin
        dig_init[c] = '0;
      end else if (LEV_W'(values[c]) > lev[c] - LEV_W'(1)) begin
        dig_init[c] = lev[c] - LEV_W'(1);
      end else begin
        dig_init[c] = LEV_W'(values[c]);
      end
    end
  end

  // shared multiplier: stride times level count, then stride times digit
  assign mul_b  = (ctrl.state == ST_MUL_LEV) ? lev[col] : dig[col];
  assign mul_p  = MW'(stride) * MW'(mul_b);
  assign dshift = XW'(TABLE_DEPTH) << rk;

  // odometer over the wildcard digits, lowest column fastest
  always_comb begin
    found     = 1'b0;
    delta_sel = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      inc_here[c]  = wild[c] && !found && ((dig[c] + LEV_W'(1)) < lev[c]);
      wrap_here[c] = wild[c] && !found && !inc_here[c];
      if (inc_here[c]) begin
        delta_sel = delta[c];
      end
      found = found | inc_here[c];
    end
    addr_sum = base + delta_sel;
    if (addr_sum >= XW'(TABLE_DEPTH)) begin
      addr_next = addr_sum - XW'(TABLE_DEPTH);
    end else begin
      addr_next = addr_sum;
    end
  end

  assign addr           = base[AW-1:0];
  assign stat.col_last  = (NCOL_W'(col) == (n_used - NCOL_W'(1)));
  assign stat.red_last  = (rk == '0);
  assign stat.walk_last = !found;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      rk  <= '0;
    end else if (ctrl.load) begin
      col <= '0;
      rk  <= RK_W'(RED_K);
    end else begin
      case (ctrl.state)
        ST_ACC: begin
          col <= col + 2'd1;
        end
        ST_REDUCE: begin
          if (rk != '0) begin
            rk <= rk - RK_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        wild[c] <= missing_mask[c] && (NCOL_W'(c) < n_used);
        dig[c]  <= dig_init[c];
      end
      stride <= FA_W'(1);
      wrap   <= '0;
      base   <= '0;
    end else begin
      case (ctrl.state)
        ST_MUL_LEV: begin
          prod       <= mul_p[FA_W-1:0];
          delta[col] <= XW'(stride) - XW'(wrap);
        end
        ST_MUL_DIG: begin
          stride <= prod;
          if (wild[col]) begin
            wrap <= wrap + prod - stride;
          end
          prod <= mul_p[FA_W-1:0];
        end
        ST_ACC: begin
          base <= base + XW'(prod);
        end
        ST_REDUCE: begin
          if (base >= dshift) begin
            base <= base - dshift;
          end
          for (int c = 0; c < NUM_COLS; c++) begin
            if (delta[c] >= dshift) begin
              delta[c] <= delta[c] - dshift;
            end
          end
        end
        ST_WALK: begin
          for (int c = 0; c < NUM_COLS; c++) begin
            if (inc_here[c]) begin
              dig[c] <= dig[c] + LEV_W'(1);
            end else if (wrap_here[c]) begin
              dig[c] <= '0;
            end
          end
          base <= addr_next;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/wcc_cell_unit.sv
// Cell update stage: takes the read count (with write-to-read bypass),
// writes back the saturated increment or decrement, or tracks the minimum.
// Depends on wcc_pkg.
`default_nettype none

module wcc_cell_unit #(
  parameter int COUNT_WIDTH = wcc_pkg::DEF_COUNT_WIDTH,
  parameter int AW          = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  wcc_pkg::cu_ctrl_t         ctrl,
  input  logic [wcc_pkg::OP_W-1:0]  op,
  input  logic [AW-1:0]             rd_addr,
  input  logic [COUNT_WIDTH-1:0]    ram_q,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [COUNT_WIDTH-1:0]    wr_data,
  output logic [COUNT_WIDTH-1:0]    min_count
);
  import wcc_pkg::*;

  logic                   s1_v;
  logic                   byp_v;
  logic [COUNT_WIDTH-1:0] byp_d;
  logic [COUNT_WIDTH-1:0] cur_count;

  assign cur_count = byp_v ? byp_d : ram_q;
  assign wr_en     = s1_v && ((op == OP_INC) || (op == OP_DEC));

  always_comb begin
    if (op == OP_INC) begin
      wr_data = (cur_count == '1) ? cur_count : cur_count + COUNT_WIDTH'(1);
    end else begin
      wr_data = (cur_count == '0) ? cur_count : cur_count - COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      byp_v <= 1'b0;
    end else begin
      s1_v  <= ctrl.issue;
      // same-edge write and read of one cell: forward the new count
      byp_v <= ctrl.issue && wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= rd_addr;
    byp_d   <= wr_data;
    if (ctrl.load) begin
      min_count <= '1;
    end else if (s1_v && (op == OP_QUERY) && (cur_count < min_count)) begin
      min_count <= cur_count;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wildcard_contingency_counter.sv
// Top level of the wildcard contingency counter: APB registers, sequencer,
// count memory, result registers. Depends on wcc_pkg, wcc_ram,
// wcc_addr_gen and wcc_cell_unit.
`default_nettype none

// Usage
// - Command channel: a transaction is taken at a rising edge with start high
//   and busy low. op selects increment, decrement or query of a row; a
//   missing column matches every level of that column.
// - Result channel: only a query answers. done is high for one cycle with
//   row_k (smallest matched count) and min_k (running minimum since the last
//   restart_min). The receiver cannot stall; results are simply presented.
// - Sequence: per used column, mixed-radix setup on the shared multiplier
//   (level, digit, accumulate); modulo reduction of base and steps; one
//   matched cell per cycle through the memory port; a drain state; and a
//   finish state for a query result. A row with every column missing visits all
//   level combinations, 65536 cells at the defaults; the single memory read
//   port bounds that rate. The unused op code is taken and ignored.
// - Reset: busy stays high while a clearing pass writes zero to every cell.
//   Registers return to 4 columns of 16 levels and the running minimum to
//   all ones. Register writes are taken anytime.
module wildcard_contingency_counter #(
  parameter int MAX_COLUMNS = wcc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_LEVELS  = wcc_pkg::DEF_MAX_LEVELS,
  parameter int COUNT_WIDTH = wcc_pkg::DEF_COUNT_WIDTH,
  parameter int TABLE_DEPTH = wcc_pkg::DEF_TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [wcc_pkg::OP_W-1:0]     op,
  input  logic [wcc_pkg::VAL_W-1:0]    value_col0,
  input  logic [wcc_pkg::VAL_W-1:0]    value_col1,
  input  logic [wcc_pkg::VAL_W-1:0]    value_col2,
  input  logic [wcc_pkg::VAL_W-1:0]    value_col3,
  input  logic [wcc_pkg::NUM_COLS-1:0] missing_mask,
  input  logic                         restart_min,
  // result channel
  output logic                         done,
  output logic [wcc_pkg::OUT_W-1:0]    row_k,
  output logic [wcc_pkg::OUT_W-1:0]    min_k,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wcc_pkg::APB_AW-1:0]   paddr,
  input  logic [wcc_pkg::APB_DW-1:0]   pwdata,
  output logic [wcc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import wcc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // configuration registers
  logic [NCOL_W-1:0]               num_columns;
  logic [LEV_W-1:0]                levels_col0;
  logic [LEV_W-1:0]                levels_col1;
  logic [LEV_W-1:0]                levels_col2;
  logic [LEV_W-1:0]                levels_col3;
  logic                            cfg_we;
  logic [REG_IDX_W-1:0]            cfg_idx;

  // sequencer
  wcc_state_t                      state;
  wcc_state_t                      state_next;
  logic                            accept;
  logic                            clearing;
  logic [AW-1:0]                   clr_cnt;
  logic [OP_W-1:0]                 op_q;
  logic                            restart_q;
  agen_ctrl_t                      agen_ctrl;
  agen_stat_t                      agen_stat;
  cu_ctrl_t                        cu_ctrl;

  // datapath
  logic [AW-1:0]                   cell_addr;
  logic                            cu_wr_en;
  logic [AW-1:0]                   cu_wr_addr;
  logic [COUNT_WIDTH-1:0]          cu_wr_data;
  logic [COUNT_WIDTH-1:0]          ram_q;
  logic [COUNT_WIDTH-1:0]          min_count;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [COUNT_WIDTH-1:0]          ram_wdata;

  // result
  logic [COUNT_WIDTH-1:0]          running_min;
  logic [COUNT_WIDTH-1:0]          min_new;

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_AW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns <= RST_NUM_COLUMNS;
      levels_col0 <= RST_LEVELS;
      levels_col1 <= RST_LEVELS;
      levels_col2 <= RST_LEVELS;
      levels_col3 <= RST_LEVELS;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NUM_COLUMNS: num_columns <= pwdata[NCOL_W-1:0];
        REG_LEVELS_COL0: levels_col0 <= pwdata[LEV_W-1:0];
        REG_LEVELS_COL1: levels_col1 <= pwdata[LEV_W-1:0];
        REG_LEVELS_COL2: levels_col2 <= pwdata[LEV_W-1:0];
        REG_LEVELS_COL3: levels_col3 <= pwdata[LEV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NUM_COLUMNS: prdata = APB_DW'(num_columns);
      REG_LEVELS_COL0: prdata = APB_DW'(levels_col0);
      REG_LEVELS_COL1: prdata = APB_DW'(levels_col1);
      REG_LEVELS_COL2: prdata = APB_DW'(levels_col2);
      REG_LEVELS_COL3: prdata = APB_DW'(levels_col3);
      default:         prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // the unused op code is taken and dropped
        if (start && ((op == OP_INC) || (op == OP_DEC) || (op == OP_QUERY))) begin
          state_next = ST_MUL_LEV;
        end
      end
      ST_MUL_LEV: state_next = ST_MUL_DIG;
      ST_MUL_DIG: state_next = ST_ACC;
      ST_ACC: begin
        state_next = agen_stat.col_last ? ST_REDUCE : ST_MUL_LEV;
      end
      ST_REDUCE: begin
        if (agen_stat.red_last) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (agen_stat.walk_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = (op_q == OP_QUERY) ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = (state != ST_IDLE);
    clearing        = (state == ST_CLEAR);
    accept          = start && (state == ST_IDLE);
    agen_ctrl.load  = accept;
    agen_ctrl.state = state;
    cu_ctrl.load    = accept;
    cu_ctrl.issue   = (state == ST_WALK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op;
      restart_q <= restart_min;
    end
  end

  // ---------------- datapath ----------------
  wcc_addr_gen #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LEVELS  (MAX_LEVELS),
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_addr_gen (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (agen_ctrl),
    .num_columns  (num_columns),
    .levels       ({levels_col3, levels_col2, levels_col1, levels_col0}),
    .values       ({value_col3, value_col2, value_col1, value_col0}),
    .missing_mask (missing_mask),
    .addr         (cell_addr),
    .stat         (agen_stat)
  );

  wcc_cell_unit #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .AW          (AW)
  ) u_cell_unit (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (cu_ctrl),
    .op        (op_q),
    .rd_addr   (cell_addr),
    .ram_q     (ram_q),
    .wr_en     (cu_wr_en),
    .wr_addr   (cu_wr_addr),
    .wr_data   (cu_wr_data),
    .min_count (min_count)
  );

  // clearing pass owns the write port right after reset
  assign ram_we    = clearing || cu_wr_en;
  assign ram_waddr = clearing ? clr_cnt : cu_wr_addr;
  assign ram_wdata = clearing ? '0 : cu_wr_data;

  wcc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cu_ctrl.issue),
    .raddr (cell_addr),
    .rdata (ram_q)
  );

  // ---------------- result ----------------
  // restart or a smaller k replaces the running minimum
  assign min_new = (restart_q || (min_count < running_min)) ? min_count : running_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      running_min <= '1;
    end else begin
      done <= (state == ST_FINISH);
      if (state == ST_FINISH) begin
        running_min <= min_new;
      end
    end
  end

  // wide counts clip to the 16-bit result fields
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      row_k <= (min_count > COUNT_WIDTH'(OUT_MAX)) ? OUT_MAX : OUT_W'(min_count);
      min_k <= (min_new > COUNT_WIDTH'(OUT_MAX)) ? OUT_MAX : OUT_W'(min_new);
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for wildcard_contingency_counter: APB setup, queued row commands,
// a transaction-level count-table predictor and a query result scoreboard.
// Depends on wcc_pkg and the wildcard_contingency_counter RTL only.

module tb_top;
  import wcc_pkg::*;

  // op code 3 has no name in the package; the block takes it and drops it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_GAP = 12;     // longest idle stretch between command bursts
  localparam int MAX_BURST = 8;
  localparam int WILD_CAP = 4096;  // random rows touch at most this many cells

  // one row command as the bench queues it
  typedef struct packed {
    logic [OP_W-1:0]                 op;
    logic [NUM_COLS-1:0][VAL_W-1:0]  vals;   // vals[c] is the level of column c
    logic [NUM_COLS-1:0]             mask;
    logic                            restart;
    logic                            drain_first;  // hold off until every query answered
  } row_cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] row_k;
    logic [OUT_W-1:0] min_k;
  } k_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      op = '0;
  logic [VAL_W-1:0]     value_col0 = '0;
  logic [VAL_W-1:0]     value_col1 = '0;
  logic [VAL_W-1:0]     value_col2 = '0;
  logic [VAL_W-1:0]     value_col3 = '0;
  logic [NUM_COLS-1:0]  missing_mask = '0;
  logic                 restart_min = 1'b0;
  logic                 done;
  logic [OUT_W-1:0]     row_k;
  logic [OUT_W-1:0]     min_k;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  wildcard_contingency_counter dut (
    .clk, .rst,
    .start, .busy, .op,
    .value_col0, .value_col1, .value_col2, .value_col3,
    .missing_mask, .restart_min,
    .done, .row_k, .min_k,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow of the block: count table, running minimum and register copies.
  // Counts are COUNT_WIDTH (16) bits, so they fit the result ports as is.
  // ---------------------------------------------------------------------
  bit [OUT_W-1:0]     tally [DEF_TABLE_DEPTH];
  logic [OUT_W-1:0]   run_min = '1;          // all ones until the first query
  logic [NCOL_W-1:0]  cfg_columns = RST_NUM_COLUMNS;
  logic [LEV_W-1:0]   cfg_levels [NUM_COLS] = '{RST_LEVELS, RST_LEVELS, RST_LEVELS, RST_LEVELS};
  int unsigned        last_cells = 0;        // cells touched by the latest transaction

  row_cmd_t   pending_rows [$];
  k_result_t  pending_k [$];
  row_cmd_t   cur_row;
  int unsigned rows_issued = 0;
  int unsigned rows_taken = 0;
  int unsigned fail_count = 0;
  longint     cycle_budget = 0;
  longint     cycle_count = 0;

  // column count 0 behaves as 1, anything past the build limit as the limit
  function automatic int unsigned eff_columns();
    int unsigned n;
    n = 32'(cfg_columns);
    if (n < 1) n = 1;
    if (n > DEF_MAX_COLUMNS) n = DEF_MAX_COLUMNS;
    return n;
  endfunction

  function automatic int unsigned eff_levels(int c);
    int unsigned l;
    l = 32'(cfg_levels[c]);
    if (l < 1) l = 1;
    if (l > DEF_MAX_LEVELS) l = DEF_MAX_LEVELS;
    return l;
  endfunction

  // number of cells a mask spans under the current setup
  function automatic int unsigned matched_cells(logic [NUM_COLS-1:0] m);
    int unsigned cells;
    cells = 1;
    for (int c = 0; c < eff_columns(); c++)
      if (m[c]) cells *= eff_levels(c);
    return cells;
  endfunction

  // Odometer walk over every matched cell. Wildcard digits sweep, fixed
  // digits sit at their (clipped) level. Increments and decrements saturate;
  // for a query the smallest count seen comes back.
  function automatic logic [OUT_W-1:0] visit_cells(row_cmd_t r);
    int unsigned n, addr, stride;
    int unsigned lev [NUM_COLS];
    int unsigned dig [NUM_COLS];
    logic [OUT_W-1:0] low;
    logic more;
    n = eff_columns();
    low = '1;
    last_cells = 0;
    for (int c = 0; c < n; c++) begin
      lev[c] = eff_levels(c);
      dig[c] = r.mask[c] ? 0 : ((32'(r.vals[c]) > lev[c] - 1) ? lev[c] - 1 : 32'(r.vals[c]));
    end
    more = 1'b1;
    while (more) begin
      addr = 0;
      stride = 1;
      for (int c = 0; c < n; c++) begin
        addr += dig[c] * stride;
        stride *= lev[c];
      end
      addr = addr % DEF_TABLE_DEPTH;
      case (r.op)
        OP_INC:  if (tally[addr] != '1) tally[addr] = tally[addr] + 1'b1;
        OP_DEC:  if (tally[addr] != '0) tally[addr] = tally[addr] - 1'b1;
        default: if (tally[addr] < low) low = tally[addr];
      endcase
      last_cells++;
      // advance the lowest wildcard digit that has room, carry otherwise
      more = 1'b0;
      for (int c = 0; c < n; c++) begin
        if (r.mask[c]) begin
          if (dig[c] + 1 < lev[c]) begin
            dig[c]++;
            more = 1'b1;
            break;
          end
          dig[c] = 0;
        end
      end
    end
    return low;
  endfunction

  // Apply one accepted transaction to the shadow; a query leaves an answer behind.
  task automatic apply_row(row_cmd_t r);
    logic [OUT_W-1:0] k;
    last_cells = 0;
    if (r.op == OP_QUERY) begin
      k = visit_cells(r);
      if (r.restart || k < run_min) run_min = k;
      pending_k.push_back('{row_k: k, min_k: run_min});
    end else if (r.op == OP_INC || r.op == OP_DEC) begin
      void'(visit_cells(r));
    end
  endtask

  // ---------------------------------------------------------------------
  // Command driver: bursts of transactions with random gaps in between.
  // The sampled start/busy are the values before this edge.
  // ---------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : drive_rows
    logic taken;
    if (rst) begin
      start <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        apply_row(cur_row);
        rows_taken++;
      end
      if (start && !taken) begin
        // block still busy: hold the command steady
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_rows.size() != 0 &&
                   !(pending_rows[0].drain_first && pending_k.size() != 0)) begin
        cur_row = pending_rows.pop_front();
        op           <= cur_row.op;
        value_col0   <= cur_row.vals[0];
        value_col1   <= cur_row.vals[1];
        value_col2   <= cur_row.vals[2];
        value_col3   <= cur_row.vals[3];
        missing_mask <= cur_row.mask;
        restart_min  <= cur_row.restart;
        start        <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, MAX_BURST);
          gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, MAX_GAP);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: every done pulse must match the oldest open query.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    k_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_k.size() == 0) begin
        $display("%0t: unexpected query result row_k=%0d min_k=%0d", $time, row_k, min_k);
        fail_count++;
      end else begin
        want = pending_k.pop_front();
        if (row_k !== want.row_k) begin
          $display("%0t: row_k expected %0d, got %0d", $time, want.row_k, row_k);
          fail_count++;
        end
        if (min_k !== want.min_k) begin
          $display("%0t: min_k expected %0d, got %0d", $time, want.min_k, min_k);
          fail_count++;
        end
      end
    end
  end

  // watchdog; the budget grows with every queued transaction
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 8 * DEF_TABLE_DEPTH) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Configuration and stimulus helpers
  // ---------------------------------------------------------------------

  // APB write (setup + access), then a read back of the register
  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] field_mask;
    field_mask = (idx == REG_NUM_COLUMNS) ? APB_DW'(3'h7) : APB_DW'(5'h1F);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);  // register takes the data here
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_NUM_COLUMNS) cfg_columns = val[NCOL_W-1:0];
    else cfg_levels[2'(idx - REG_LEVELS_COL0)] = val[LEV_W-1:0];
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((prdata & field_mask) !== (val & field_mask)) begin
      $display("%0t: register %0d read expected %0d, got %0d", $time, idx,
               val & field_mask, prdata & field_mask);
      fail_count++;
    end
  endtask

  task automatic set_config(int unsigned ncols, int unsigned l0, int unsigned l1,
                            int unsigned l2, int unsigned l3);
    reg_write(REG_NUM_COLUMNS, ncols);
    reg_write(REG_LEVELS_COL0, l0);
    reg_write(REG_LEVELS_COL1, l1);
    reg_write(REG_LEVELS_COL2, l2);
    reg_write(REG_LEVELS_COL3, l3);
  endtask

  // vals packs the four column levels, column 0 in the low nibble
  task automatic queue_row(logic [OP_W-1:0] o, logic [15:0] vals, logic [NUM_COLS-1:0] m,
                           logic rs, logic df);
    row_cmd_t r;
    r.op = o;
    r.vals = vals;
    r.mask = m;
    r.restart = rs;
    r.drain_first = df;
    cycle_budget += longint'(matched_cells(m) + 64 + MAX_GAP);
    pending_rows.push_back(r);
    rows_issued++;
  endtask

  // Random mix, increments most often so counts pile up and queries see nonzero k.
  // Values land in range half the time, else anywhere in the 4-bit field so
  // clipping to the top level gets hit. Wide masks are trimmed to keep runs short.
  task automatic queue_random_rows(int count);
    int unsigned pick;
    logic [OP_W-1:0] o;
    logic [15:0] vals;
    logic [NUM_COLS-1:0] m;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) o = OP_INC;
      else if (pick < 6) o = OP_DEC;
      else if (pick < 9) o = OP_QUERY;
      else o = OP_UNUSED;
      for (int c = 0; c < NUM_COLS; c++)
        vals[4*c +: 4] = VAL_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, eff_levels(c) - 1));
      m = NUM_COLS'($urandom & $urandom);
      while (matched_cells(m) > WILD_CAP) m = m & (m - 1'b1);
      queue_row(o, vals, m, $urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0);
    end
  endtask

  // Wait until every queued transaction is taken and answered and the block
  // is idle, then give the last walk time to retire before touching registers.
  task automatic wait_quiet();
    do @(posedge clk);
    while (rows_taken != rows_issued || pending_k.size() != 0);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (last_cells + 24) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // clearing pass: busy for a full table sweep
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // full-size table, 4 columns of 16 levels
    set_config(32'(RST_NUM_COLUMNS), 32'(RST_LEVELS), 32'(RST_LEVELS),
               32'(RST_LEVELS), 32'(RST_LEVELS));
    queue_row(OP_QUERY,  16'h0000, 4'h0, 1'b0, 1'b0);  // query before any restart
    queue_row(OP_UNUSED, 16'hFFFF, 4'hF, 1'b1, 1'b0);  // ignored op code
    queue_row(OP_DEC,    16'hFFFF, 4'h0, 1'b0, 1'b0);  // decrement at zero
    repeat (3) queue_row(OP_INC, 16'hFFFF, 4'h0, 1'b0, 1'b0);
    queue_row(OP_QUERY,  16'hFFFF, 4'h0, 1'b1, 1'b1);  // sender drains first
    queue_row(OP_QUERY,  16'hFFF0, 4'h1, 1'b0, 1'b0);  // column 0 wildcard
    queue_row(OP_INC,    16'h0000, 4'hF, 1'b0, 1'b0);  // every cell
    queue_row(OP_QUERY,  16'h5A5A, 4'hF, 1'b1, 1'b0);  // min over the whole table
    queue_row(OP_DEC,    16'h0005, 4'hE, 1'b0, 1'b0);  // three wildcard columns
    repeat (2) queue_row(OP_INC, 16'h0000, 4'h0, 1'b0, 1'b0);
    queue_row(OP_QUERY,  16'h0000, 4'h0, 1'b1, 1'b0);
    queue_row(OP_QUERY,  16'hFFFF, 4'h0, 1'b0, 1'b0);
    queue_row(OP_QUERY,  16'h0005, 4'h0, 1'b0, 1'b0);  // running min drops to zero
    queue_random_rows(15);
    wait_quiet();

    // zero registers: one column of one level, everything lands on cell 0
    set_config(0, 0, 0, 0, 0);
    queue_row(OP_INC,   16'hFFFF, 4'hE, 1'b0, 1'b0);   // mask bits of unused columns
    queue_row(OP_QUERY, 16'hABCD, 4'hE, 1'b1, 1'b0);
    queue_random_rows(10);
    wait_quiet();

    // over-range registers clip to the build limits
    set_config(7, 31, 17, 1, 3);
    queue_random_rows(15);
    wait_quiet();

    // random setups, small level counts most of the time
    for (int p = 0; p < 4; p++) begin
      set_config($urandom_range(0, 7),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5));
      queue_random_rows(10);
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
